// ===== rtl/spq_pkg.sv =====
// Shared types, constants and status codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Default number of queue slots
  localparam int SPQ_CAPACITY = 64;

  // Field widths
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 16;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 3;

  // Request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // One stored queue entry
  typedef struct packed {
    logic [HANDLE_W-1:0]      handle;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic eval;  // register compare flags against the held request
    logic ins;   // commit an insert: open a gap and drop the new entry in
    logic rem;   // commit a remove: move every entry one slot to the front
  } cell_cmd_t;

endpackage

// ===== rtl/spq_req_if.sv =====
// Request channel: valid/ready handshake with the request item payload.
`timescale 1ns / 1ps

interface spq_req_if
  import spq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [HANDLE_W-1:0]      item_handle;
  logic [KIND_W-1:0]        item_kind;
  logic signed [PRIO_W-1:0] item_priority;

  modport source (
    output valid, req_type, item_handle, item_kind, item_priority,
    input  ready
  );

  modport sink (
    input  valid, req_type, item_handle, item_kind, item_priority,
    output ready
  );
endinterface

// ===== rtl/spq_rsp_if.sv =====
// Result channel: valid/ready handshake with the result item payload.
`timescale 1ns / 1ps

interface spq_rsp_if
  import spq_pkg::*;
#(
  parameter int CNT_W = $clog2(SPQ_CAPACITY + 1)
) ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [HANDLE_W-1:0]      out_handle;
  logic [KIND_W-1:0]        out_kind;
  logic signed [PRIO_W-1:0] out_priority;
  logic [CNT_W-1:0]         entry_count;

  modport source (
    output valid, status, out_handle, out_kind, out_priority, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_kind, out_priority, entry_count,
    output ready
  );
endinterface

// ===== rtl/stable_priority_queue_core.sv =====
// Sequence: an accepted request passes the EVAL state (compare flags registered), then
//   APPLY (commit over the slot chain, result registered); a new request is taken only in
//   IDLE, and a result waiting in the output register holds the commit.
// Reset: synchronous active-low rst_n clears the sequencer, entry count and
//   result valid; slot contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = SPQ_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_req_if.sink   in_req,
  spq_rsp_if.source out_rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                req_type_r;
  entry_t              req_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  entry_t              out_entry_r, out_entry_nxt;

  cell_cmd_t           cmd;
  entry_t              cell_q [CAPACITY];
  logic [CAPACITY-1:0] before_vec;
  logic [CAPACITY-1:0] match_vec;
  logic                advance;
  logic                dup;
  logic                in_fire;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign advance      = (state_r == S_APPLY) && (!out_valid_r || out_rsp.ready);
  assign dup          = |match_vec;

  // Capture the request item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r  <= in_req.req_type;
      req_r.handle <= in_req.item_handle;
      req_r.kind   <= in_req.item_kind;
      req_r.prio   <= in_req.item_priority;
    end
  end

  // Decide the outcome and drive the chain
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = status_r;
    out_entry_nxt = out_entry_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (advance) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_entry_nxt = '0;
          if (req_type_r == REQ_INSERT) begin
            if (req_r.handle == '0) begin
              status_nxt = ST_NULL;
            end else if (dup) begin
              status_nxt = ST_DUP;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_OK;
              cmd.ins    = 1'b1;
              count_nxt  = count_r + 1'b1;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              status_nxt    = ST_OK;
              out_entry_nxt = cell_q[0];
              cmd.rem       = 1'b1;
              count_nxt     = count_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_entry_r <= out_entry_nxt;
  end

  // Row of slots, front of the queue at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_b;
    entry_t right_e;

    if (i == 0) begin : g_first
      assign left_e = req_r;
      assign left_b = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = before_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_entry   (req_r),
      .count       (count_r),
      .left_entry  (left_e),
      .left_ahead  (left_b),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .ahead       (before_vec[i]),
      .match       (match_vec[i])
    );
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = status_r;
  assign out_rsp.out_handle   = out_entry_r.handle;
  assign out_rsp.out_kind     = out_entry_r.kind;
  assign out_rsp.out_priority = out_entry_r.prio;
  assign out_rsp.entry_count  = count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> ($past(state_r) == S_APPLY))
    else $error("entry count moved outside commit");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_APPLY))
    else $error("result raised outside commit");

  a_ok_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_type_r == REQ_INSERT) && (count_r == CNT_W'(CAPACITY)))
      |=> (status_r != ST_OK))
    else $error("insert accepted into full queue");
`endif

endmodule

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  entry_t           new_entry,
  input  logic [CNT_W-1:0] count,
  input  entry_t           left_entry,
  input  logic             left_ahead,
  input  entry_t           right_entry,
  output entry_t           entry,
  output logic             ahead,
  output logic             match
);

  entry_t entry_r, entry_nxt;
  logic   ahead_r, ahead_nxt;
  logic   match_r, match_nxt;
  logic   occupied;

  assign occupied = CNT_W'(IDX) < count;

  // Compare the held request against this slot
  always_comb begin
    ahead_nxt = ahead_r;
    match_nxt = match_r;
    if (cmd.eval) begin
      ahead_nxt = !occupied || ($signed(new_entry.prio) < $signed(entry_r.prio));
      match_nxt = occupied && (entry_r.handle == new_entry.handle);
    end
  end

  // Shift towards the back on insert, towards the front on remove
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (left_ahead) begin
        entry_nxt = left_entry;
      end else if (ahead_r) begin
        entry_nxt = new_entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    ahead_r <= ahead_nxt;
    match_r <= match_nxt;
  end

  assign entry = entry_r;
  assign ahead = ahead_r;
  assign match = match_r;

endmodule

// ===== dv/stable_priority_queue_core_tb.sv =====
// Self-checking testbench for the stable priority queue core.
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = SPQ_CAPACITY;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RX_HOLD_AT  = 300;   // results seen before the long receiver hold
  localparam int RX_HOLD_LEN = 250;   // cycles of that hold
  localparam int STEADY_LO   = 500;   // window with no idling on either side
  localparam int STEADY_HI   = 650;
  localparam int DRAIN_WAIT  = 12;    // settle cycles after the last result

  // Result of one request as the queue should report it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    entry_t              taken;
    logic [CNT_W-1:0]    count;
  } queue_result_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct {
    logic          rtype;
    entry_t        req;
    bit            typed;
    queue_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  spq_req_if                     req_bus ();
  spq_rsp_if #(.CNT_W(CNT_W))    rsp_bus ();

  stable_priority_queue_core #(
    .CAPACITY (QUEUE_DEPTH),
    .CNT_W    (CNT_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  entry_t        shadow_entries[$];   // predicted queue contents, front leaves first
  queue_result_t pending_results[$];  // expected results, oldest first
  dir_row_t      dir_table[$];
  int            sent_count;
  int            got_count;
  int            error_count;
  bit            rx_hold_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("stable_priority_queue_core_tb NOT OK");
    $finish;
  end

  // Predict one request and advance the shadow queue
  function automatic queue_result_t predict_queue_op(input logic rtype, input entry_t req);
    queue_result_t res;
    int            pos;
    bit            seen;
    res  = '0;
    seen = 1'b0;
    if (rtype == REQ_INSERT) begin
      foreach (shadow_entries[i]) begin
        if (shadow_entries[i].handle == req.handle) seen = 1'b1;
      end
      if (req.handle == '0) begin
        res.status = ST_NULL;
      end else if (seen) begin
        res.status = ST_DUP;
      end else if (shadow_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // go behind every entry of equal priority
        pos = 0;
        while (pos < shadow_entries.size() &&
               !($signed(req.prio) < $signed(shadow_entries[pos].prio)))
          pos++;
        shadow_entries.insert(pos, req);
        res.status = ST_OK;
      end
    end else if (shadow_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.taken  = shadow_entries.pop_front();
      res.status = ST_OK;
    end
    res.count = CNT_W'(shadow_entries.size());
    return res;
  endfunction

  function automatic dir_row_t dir_row(input logic rtype, input logic [15:0] h,
                                       input logic [15:0] k, input logic [31:0] p,
                                       input bit typed, input logic [2:0] st,
                                       input logic [15:0] oh, input logic [15:0] ok,
                                       input logic [31:0] op, input int cnt);
    dir_row_t row;
    row.rtype        = rtype;
    row.req.handle   = h;
    row.req.kind     = k;
    row.req.prio     = p;
    row.typed        = typed;
    row.want.status  = st;
    row.want.taken.handle = oh;
    row.want.taken.kind   = ok;
    row.want.taken.prio   = op;
    row.want.count   = CNT_W'(cnt);
    return row;
  endfunction

  // Offer one item, wait for it to be taken, then log its expectation
  task automatic send_request(input logic rtype, input entry_t req, input bit typed,
                              input queue_result_t typed_res);
    queue_result_t predicted;
    int            gap;
    if (!(sent_count >= STEADY_LO && sent_count < STEADY_HI) &&
        $urandom_range(0, 99) < 13) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        req_bus.valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= rtype;
    req_bus.item_handle   <= req.handle;
    req_bus.item_kind     <= req.kind;
    req_bus.item_priority <= req.prio;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    predicted = predict_queue_op(rtype, req);
    pending_results.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  // Build a random request (inserts at insert_pct percent), biased towards valid handles and ties
  task automatic random_request(input int insert_pct, output logic rtype, output entry_t req);
    int r;
    rtype      = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
    req.kind   = 16'($urandom);
    r          = $urandom_range(0, 99);
    if (r < 4)
      req.handle = '0;
    else if (r < 70)
      req.handle = 16'($urandom_range(1, 120));
    else if (r < 85 && shadow_entries.size() != 0)
      req.handle = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].handle;
    else
      req.handle = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50)
      req.prio = 32'($signed($urandom_range(0, 6)) - 3);
    else if (r < 70)
      req.prio = $urandom;
    else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       req.prio = 32'h8000_0000;
        1:       req.prio = 32'h7FFF_FFFF;
        2:       req.prio = 32'h0000_0000;
        default: req.prio = 32'hFFFF_FFFF;
      endcase
    end else if (shadow_entries.size() != 0)
      req.prio = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)].prio;
    else
      req.prio = $urandom;
  endtask

  // Stimulus
  initial begin
    logic          rtype;
    entry_t        req;
    queue_result_t none;
    none                  = '0;
    sent_count            = 0;
    rst_n                 = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_INSERT;
    req_bus.item_handle   = '0;
    req_bus.item_kind     = '0;
    req_bus.item_priority = '0;

    // Directed rows: empty, null, extremes, duplicate, ties, unused fields on remove
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 1,
                                ST_EMPTY, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0000, 16'h1234, 32'h0, 1,
                                ST_NULL, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_INSERT, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1,
                                ST_OK, 0, 0, 0, 1));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0001, 16'h0000, 32'h8000_0000, 1,
                                ST_OK, 0, 0, 0, 2));
    dir_table.push_back(dir_row(REQ_INSERT, 16'hFFFF, 16'h0000, 32'h0, 1,
                                ST_DUP, 0, 0, 0, 2));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
                                ST_OK, 16'h0001, 16'h0000, 32'h8000_0000, 1));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0002, 16'hAAAA, 32'd5, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0003, 16'h5555, 32'd5, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0004, 16'h0001, 32'd5, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_INSERT, 16'h0005, 16'h0002, 32'hFFFF_FFFF, 0,
                                0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'h0000, 16'h0000, 32'h0, 1,
                                ST_OK, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 0));
    dir_table.push_back(dir_row(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1,
                                ST_EMPTY, 0, 0, 0, 0));

    // Hold reset, then release it at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_table[i])
      send_request(dir_table[i].rtype, dir_table[i].req, dir_table[i].typed,
                   dir_table[i].want);

    // Fill to capacity with ties, probe full/duplicate/null, then drain past empty
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      req.handle = 16'h0100 + 16'(i);
      req.kind   = 16'($urandom);
      req.prio   = 32'($signed($urandom_range(0, 4)) - 2);
      send_request(REQ_INSERT, req, 1'b0, none);
    end
    req = '{handle: 16'h7777, kind: 16'h1111, prio: 32'h0};
    send_request(REQ_INSERT, req, 1'b0, none);
    req.handle = 16'h0100;
    send_request(REQ_INSERT, req, 1'b0, none);
    req.handle = 16'h0000;
    send_request(REQ_INSERT, req, 1'b0, none);
    send_request(REQ_REMOVE, req, 1'b0, none);
    req = '{handle: 16'h7777, kind: 16'h2222, prio: 32'h8000_0000};
    send_request(REQ_INSERT, req, 1'b0, none);
    repeat (QUEUE_DEPTH + 1) send_request(REQ_REMOVE, req, 1'b0, none);

    // Random rounds: fill-biased then drain-biased, so the count sweeps the range
    for (int round = 0; round < 6; round++) begin
      if (round == 3) begin
        // pause the sender until every result is back
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      repeat (85) begin
        random_request(85, rtype, req);
        send_request(rtype, req, 1'b0, none);
      end
      repeat (65) begin
        random_request(15, rtype, req);
        send_request(rtype, req, 1'b0, none);
      end
    end

    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("stable_priority_queue_core_tb OK");
    else
      $display("stable_priority_queue_core_tb NOT OK");
    $finish;
  end

  // Receiver: random back-pressure, one long hold, and a steady window
  initial begin
    rx_hold_done  = 1'b0;
    rsp_bus.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!rx_hold_done && got_count >= RX_HOLD_AT) begin
        rx_hold_done = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (RX_HOLD_LEN) @(negedge clk);
      end else begin
        rsp_bus.ready <= (got_count >= STEADY_LO && got_count < STEADY_HI) ||
                         ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Compare each accepted result against the oldest expectation
  initial begin
    got_count   = 0;
    error_count = 0;
  end

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual status %0d handle %h",
                 $time, rsp_bus.status, rsp_bus.out_handle);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          error_count++;
          $display("%0t: status: expected %0d, actual %0d",
                   $time, want.status, rsp_bus.status);
        end
        if (rsp_bus.out_handle !== want.taken.handle) begin
          error_count++;
          $display("%0t: out_handle: expected %h, actual %h",
                   $time, want.taken.handle, rsp_bus.out_handle);
        end
        if (rsp_bus.out_kind !== want.taken.kind) begin
          error_count++;
          $display("%0t: out_kind: expected %h, actual %h",
                   $time, want.taken.kind, rsp_bus.out_kind);
        end
        if (rsp_bus.out_priority !== want.taken.prio) begin
          error_count++;
          $display("%0t: out_priority: expected %h, actual %h",
                   $time, want.taken.prio, rsp_bus.out_priority);
        end
        if (rsp_bus.entry_count !== want.count) begin
          error_count++;
          $display("%0t: entry_count: expected %0d, actual %0d",
                   $time, want.count, rsp_bus.entry_count);
        end
      end
    end
  end

endmodule
